@@ design/ole_pkg.sv @@
`timescale 1ns / 1ps

package ole_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int VAL_W = 32;
  localparam int POS_W = 6;
  localparam int CNT_W = 7;
  localparam int REQ_W = 2;

  localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
  localparam logic [REQ_W-1:0] REQ_DELETE = 2'd2;
  localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd3;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_APPEND,
    CMD_REMOVE,
    CMD_ROTATE
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } state_t;

  typedef struct packed {
    cell_cmd_t               cmd;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
    logic [CNT_W-1:0]        count;
  } cell_ctl_t;

endpackage

@@ design/ole_cell.sv @@
`timescale 1ns / 1ps

module ole_cell #(
  parameter int IDX = 0
) (
  input  logic                               clk,
  input  ole_pkg::cell_ctl_t                 ctl,
  input  logic signed [ole_pkg::VAL_W-1:0]   lower_data,
  input  logic signed [ole_pkg::VAL_W-1:0]   upper_data,
  input  logic signed [ole_pkg::VAL_W-1:0]   head_data,
  output logic signed [ole_pkg::VAL_W-1:0]   data
);

  localparam logic [ole_pkg::CNT_W-1:0] MY_IDX = ole_pkg::CNT_W'(IDX);
  localparam logic [ole_pkg::CNT_W-1:0] NXT_IDX = ole_pkg::CNT_W'(IDX + 1);

  logic signed [ole_pkg::VAL_W-1:0] data_r;
  logic signed [ole_pkg::VAL_W-1:0] data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (ctl.cmd)
      ole_pkg::CMD_HOLD: begin
        data_nxt = data_r;
      end
      ole_pkg::CMD_PUSH_FRONT: begin
        data_nxt = (IDX == 0) ? ctl.value : lower_data;
      end
      ole_pkg::CMD_APPEND: begin
        if (ctl.count == MY_IDX) begin
          data_nxt = ctl.value;
        end
      end
      ole_pkg::CMD_REMOVE: begin
        if (MY_IDX >= {1'b0, ctl.pos}) begin
          data_nxt = upper_data;
        end
      end
      ole_pkg::CMD_ROTATE: begin
        data_nxt = (NXT_IDX == ctl.count) ? head_data : upper_data;
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data = data_r;

endmodule

@@ design/ordered_list_engine.sv @@
`timescale 1ns / 1ps

// Bounded ordered list of signed 32-bit values held in a row of cells, front at
// cell 0. Insert, append and delete each take one transaction in and give one
// result out, one per cycle while the output register is free to take it, since
// every cell shifts or loads in the same cycle. A dump gives one result per
// element, one per cycle unless out_tready holds the output, by rotating the row
// through cell 0; an empty list dumps as one result without an element. No new
// request is taken until the final result of a dump is registered. Every result
// carries the length after the request; status is set when an insert or append
// finds the list full or a delete index is not below the length.

module ordered_list_engine #(
  parameter int CAPACITY = ole_pkg::CAPACITY_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // value[31:0], position[37:32], zero pad
  input  logic [1:0]  in_tuser,  // req_type[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata, // status[0], element[32:1], length[39:33]
  output logic [0:0]  out_tuser, // element_valid[0]
  output logic        out_tlast
);

  localparam int VW = ole_pkg::VAL_W;
  localparam int CW = ole_pkg::CNT_W;
  localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE = CW'(1);

  logic [ole_pkg::REQ_W-1:0] req_type;
  logic signed [VW-1:0]      req_value;
  logic [ole_pkg::POS_W-1:0] req_pos;

  assign req_type  = in_tuser;
  assign req_value = in_tdata[VW-1:0];
  assign req_pos   = in_tdata[VW+ole_pkg::POS_W-1:VW];

  ole_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      dump_r, dump_nxt;
  ole_pkg::cell_ctl_t ctl;
  ole_pkg::cell_cmd_t cmd;

  logic                 out_valid_r;
  logic                 out_status_r, out_status_nxt;
  logic signed [VW-1:0] out_elem_r, out_elem_nxt;
  logic                 out_evalid_r, out_evalid_nxt;
  logic [CW-1:0]        out_len_r, out_len_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_load;
  logic                 out_free;
  logic                 in_fire;

  logic signed [VW-1:0] cell_data [CAPACITY];
  logic signed [VW-1:0] head;

  assign head     = cell_data[0];
  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == ole_pkg::ST_IDLE) && out_free;
  assign in_fire  = in_tvalid && in_tready;

  assign ctl.cmd   = cmd;
  assign ctl.value = req_value;
  assign ctl.pos   = req_pos;
  assign ctl.count = count_r;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VW-1:0] lower;
    logic signed [VW-1:0] upper;
    if (i == 0) begin : g_first
      assign lower = req_value;
    end else begin : g_mid_lo
      assign lower = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper = cell_data[i];
    end else begin : g_mid_hi
      assign upper = cell_data[i+1];
    end
    ole_cell #(
      .IDX(i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .lower_data (lower),
      .upper_data (upper),
      .head_data  (head),
      .data       (cell_data[i])
    );
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ole_pkg::ST_IDLE: begin
        if (in_fire && req_type == ole_pkg::REQ_DUMP && count_r > ONE) begin
          state_nxt = ole_pkg::ST_DUMP;
        end
      end
      ole_pkg::ST_DUMP: begin
        if (out_free && dump_r == ONE) begin
          state_nxt = ole_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ole_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd            = ole_pkg::CMD_HOLD;
    count_nxt      = count_r;
    dump_nxt       = dump_r;
    out_load       = 1'b0;
    out_status_nxt = 1'b0;
    out_elem_nxt   = '0;
    out_evalid_nxt = 1'b0;
    out_len_nxt    = count_r;
    out_last_nxt   = 1'b1;
    unique case (state_r)
      ole_pkg::ST_IDLE: begin
        if (in_fire) begin
          out_load = 1'b1;
          unique case (req_type)
            ole_pkg::REQ_INSERT, ole_pkg::REQ_APPEND: begin
              if (count_r >= CAP_CNT) begin
                out_status_nxt = 1'b1;
              end else begin
                cmd = (req_type == ole_pkg::REQ_INSERT) ? ole_pkg::CMD_PUSH_FRONT
                                                        : ole_pkg::CMD_APPEND;
                count_nxt   = count_r + ONE;
                out_len_nxt = count_r + ONE;
              end
            end
            ole_pkg::REQ_DELETE: begin
              if ({1'b0, req_pos} >= count_r) begin
                out_status_nxt = 1'b1;
              end else begin
                cmd         = ole_pkg::CMD_REMOVE;
                count_nxt   = count_r - ONE;
                out_len_nxt = count_r - ONE;
              end
            end
            ole_pkg::REQ_DUMP: begin
              if (count_r != '0) begin
                cmd            = ole_pkg::CMD_ROTATE;
                out_elem_nxt   = head;
                out_evalid_nxt = 1'b1;
                out_last_nxt   = (count_r == ONE);
                dump_nxt       = count_r - ONE;
              end
            end
          endcase
        end
      end
      ole_pkg::ST_DUMP: begin
        if (out_free) begin
          out_load       = 1'b1;
          cmd            = ole_pkg::CMD_ROTATE;
          out_elem_nxt   = head;
          out_evalid_nxt = 1'b1;
          out_last_nxt   = (dump_r == ONE);
          dump_nxt       = dump_r - ONE;
        end
      end
      default: begin
        cmd = ole_pkg::CMD_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ole_pkg::ST_IDLE;
      count_r     <= '0;
      dump_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      dump_r  <= dump_nxt;
      if (out_free) begin
        out_valid_r <= out_load;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_elem_r   <= out_elem_nxt;
      out_evalid_r <= out_evalid_nxt;
      out_len_r    <= out_len_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_len_r, out_elem_r, out_status_r};
  assign out_tuser  = out_evalid_r;
  assign out_tlast  = out_last_r;

endmodule
